// ===== hw/rtl/all_pairs_shortest_path_core_assert.svh =====
// Assertion macros for the shortest path core.
// Each macro takes a label, the clock, the active-low reset and its operands.
`ifndef ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define APSP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
`define APSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define APSP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define APSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/apsp_pkg.sv =====
package apsp_pkg;

  // Field widths of the item and result ports
  localparam int FUNC_W = 2;
  localparam int VERT_W = 7;
  localparam int EDGE_W = 16;
  localparam int DIST_W = 22;

  // Default vertex capacity and register reset value
  localparam int MAX_VERTICES_DEF = 64;
  localparam int VCOUNT_RESET     = 64;

  // Significant bits of an edge weight
  localparam int WEIGHT_BITS = 16;
  localparam int WMASK_BITS  = (WEIGHT_BITS < EDGE_W) ? WEIGHT_BITS : EDGE_W;
  localparam logic [EDGE_W-1:0] WEIGHT_MASK = EDGE_W'((32'd1 << WMASK_BITS) - 32'd1);

  // Saturation ceiling of a stored distance
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EDGE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  // One matrix entry: finite flag, distance, last intermediate vertex
  typedef struct packed {
    logic              finite;
    logic [DIST_W-1:0] len;
    logic [VERT_W-1:0] via;
  } entry_t;

endpackage

// ===== hw/rtl/all_pairs_shortest_path_core.sv =====
// Edge and read items: S_EXEC, S_ITEM, then the result strobe (a bad vertex skips S_ITEM).
// Clear item: sweeps all 2**(2*clog2(MAX_VERTICES)) entries, one entry written per cycle.
// Run item: for n vertices in use, the one matrix write port and one add-compare unit
// handle one (k, i, j) step per cycle in S_RUN_J, pausing in S_RUN_IK/S_RUN_IKW per row.
// busy stays high until the result strobe; one item at a time, results cannot be stalled.
// Reset (rst_n low, synchronous) starts a clearing pass over all matrix entries.
`include "all_pairs_shortest_path_core_assert.svh"

module all_pairs_shortest_path_core #(
  parameter int MAX_VERTICES = apsp_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // item channel
  input  logic                        start,
  output logic                        busy,
  input  logic [apsp_pkg::FUNC_W-1:0] in_func,
  input  logic [apsp_pkg::VERT_W-1:0] in_vertex_a,
  input  logic [apsp_pkg::VERT_W-1:0] in_vertex_b,
  input  logic [apsp_pkg::EDGE_W-1:0] in_edge_weight,
  // result channel
  output logic                        out_valid,
  output logic [apsp_pkg::DIST_W-1:0] out_distance,
  output logic                        out_reachable,
  output logic [apsp_pkg::VERT_W-1:0] out_via_vertex,
  output logic                        out_status,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [apsp_pkg::VERT_W-1:0] cfg_data
);
  import apsp_pkg::*;

  localparam int IDX_W     = $clog2(MAX_VERTICES);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLEAR   = 3'd1;
  localparam logic [2:0] S_EXEC    = 3'd2;
  localparam logic [2:0] S_ITEM    = 3'd3;
  localparam logic [2:0] S_RUN_IK  = 3'd4;
  localparam logic [2:0] S_RUN_IKW = 3'd5;
  localparam logic [2:0] S_RUN_J   = 3'd6;
  localparam logic [2:0] S_RUN_END = 3'd7;

  // Matrix is symmetric: each pair lives at {low index, high index}
  function automatic logic [ADDR_W-1:0] pair_addr(input logic [IDX_W-1:0] x,
                                                  input logic [IDX_W-1:0] y);
    return (x < y) ? {x, y} : {y, x};
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [VERT_W-1:0] vcount_r;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_item_r, clr_item_nxt;

  // captured item
  logic [FUNC_W-1:0] func_r;
  logic [VERT_W-1:0] a_r, b_r;
  logic [EDGE_W-1:0] w_r;

  // loop counters, cached d[i][k]
  logic [IDX_W-1:0]  k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  entry_t            ik_r, ik_nxt;

  // relaxation stage behind the read
  logic              p_v_r, p_v_nxt;
  logic [IDX_W-1:0]  p_i_r, p_i_nxt, p_j_r, p_j_nxt, p_k_r, p_k_nxt;

  // result registers
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_reach_r, out_reach_nxt;
  logic [VERT_W-1:0] out_via_r, out_via_nxt;
  logic              out_status_r, out_status_nxt;

  // matrix memory
  entry_t            mem [MEM_DEPTH];
  entry_t            rd_a_r, rd_b_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa, ra_a, ra_b;
  entry_t            mem_wd;

  logic              accept;
  logic [VERT_W-1:0] n_eff;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  a_idx, b_idx;
  logic              pair_ok;
  logic [DIST_W:0]   sum_raw;
  logic [DIST_W-1:0] sum_sat;
  logic              improve;
  logic              relax_phase;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Vertices in use, capped at capacity
  assign n_eff    = (int'(vcount_r) > MAX_VERTICES) ? VERT_W'(MAX_VERTICES) : vcount_r;
  assign last_idx = IDX_W'(n_eff - VERT_W'(1));
  assign a_idx    = IDX_W'(a_r - VERT_W'(1));
  assign b_idx    = IDX_W'(b_r - VERT_W'(1));
  assign pair_ok  = (a_r != '0) && (a_r <= n_eff) && (b_r != '0) && (b_r <= n_eff);

  // Shared add-compare unit: d[i][k] + d[k][j] against d[i][j]
  assign sum_raw = {1'b0, ik_r.len} + {1'b0, rd_a_r.len};
  assign sum_sat = sum_raw[DIST_W] ? DIST_MAX : sum_raw[DIST_W-1:0];
  assign improve = p_v_r && ik_r.finite && rd_a_r.finite &&
                   (!rd_b_r.finite || (rd_b_r.len > sum_sat));

  // States in which a relaxation step may still be in flight
  assign relax_phase = (state_r == S_RUN_J) || (state_r == S_RUN_IK) ||
                       (state_r == S_RUN_END);

  // Read address selection
  always_comb begin
    case (state_r)
      S_EXEC:   ra_a = pair_addr(a_idx, b_idx);
      S_RUN_IK: ra_a = pair_addr(i_r, k_r);
      default:  ra_a = pair_addr(k_r, j_r);
    endcase
    ra_b = pair_addr(i_r, j_r);
  end

  // Write port: clearing sweep, edge load, or relaxation update
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pair_addr(p_i_r, p_j_r);
    mem_wd = '{finite: 1'b1, len: sum_sat, via: VERT_W'(p_k_r) + VERT_W'(1)};
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_r;
      mem_wd = '0;
      mem_wd.finite = (clr_cnt_r[ADDR_W-1:IDX_W] == clr_cnt_r[IDX_W-1:0]);
    end else if ((state_r == S_ITEM) && (func_r == FUNC_EDGE) && (a_r != b_r)) begin
      mem_we = 1'b1;
      mem_wa = pair_addr(a_idx, b_idx);
      mem_wd = '{finite: 1'b1, len: DIST_W'(w_r), via: rd_a_r.via};
    end else if (improve) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_item_nxt   = clr_item_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    ik_nxt         = ik_r;
    p_v_nxt        = 1'b0;
    p_i_nxt        = p_i_r;
    p_j_nxt        = p_j_r;
    p_k_nxt        = p_k_r;
    out_valid_nxt  = 1'b0;
    out_dist_nxt   = out_dist_r;
    out_reach_nxt  = out_reach_r;
    out_via_nxt    = out_via_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (func_r)
          FUNC_CLEAR: begin
            clr_cnt_nxt  = '0;
            clr_item_nxt = 1'b1;
            state_nxt    = S_CLEAR;
          end
          FUNC_RUN: begin
            if (n_eff == '0) begin
              out_valid_nxt  = 1'b1;
              out_dist_nxt   = '0;
              out_reach_nxt  = 1'b0;
              out_via_nxt    = '0;
              out_status_nxt = 1'b0;
              state_nxt      = S_IDLE;
            end else begin
              k_nxt     = '0;
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = S_RUN_IK;
            end
          end
          default: begin
            // edge or read: bad vertex answers at once
            if (!pair_ok) begin
              out_valid_nxt  = 1'b1;
              out_dist_nxt   = '0;
              out_reach_nxt  = 1'b0;
              out_via_nxt    = '0;
              out_status_nxt = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              state_nxt = S_ITEM;
            end
          end
        endcase
      end
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (&clr_cnt_r) begin
          out_valid_nxt  = clr_item_r;
          out_dist_nxt   = '0;
          out_reach_nxt  = 1'b0;
          out_via_nxt    = '0;
          out_status_nxt = 1'b0;
          clr_item_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      S_ITEM: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        if (func_r == FUNC_READ) begin
          out_dist_nxt  = rd_a_r.finite ? rd_a_r.len : '0;
          out_reach_nxt = rd_a_r.finite;
          out_via_nxt   = rd_a_r.via;
        end else begin
          out_dist_nxt  = '0;
          out_reach_nxt = 1'b0;
          out_via_nxt   = '0;
        end
        state_nxt = S_IDLE;
      end
      S_RUN_IK: begin
        state_nxt = S_RUN_IKW;
      end
      S_RUN_IKW: begin
        ik_nxt    = rd_a_r;
        j_nxt     = '0;
        state_nxt = S_RUN_J;
      end
      S_RUN_J: begin
        p_v_nxt = 1'b1;
        p_i_nxt = i_r;
        p_j_nxt = j_r;
        p_k_nxt = k_r;
        if (j_r == last_idx) begin
          j_nxt = '0;
          if (i_r == last_idx) begin
            i_nxt = '0;
            if (k_r == last_idx) begin
              state_nxt = S_RUN_END;
            end else begin
              k_nxt     = k_r + IDX_W'(1);
              state_nxt = S_RUN_IK;
            end
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_RUN_IK;
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_RUN_END: begin
        out_valid_nxt  = 1'b1;
        out_dist_nxt   = '0;
        out_reach_nxt  = 1'b0;
        out_via_nxt    = '0;
        out_status_nxt = 1'b0;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_item_r  <= 1'b0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      vcount_r    <= VERT_W'(VCOUNT_RESET);
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_item_r  <= clr_item_nxt;
      p_v_r       <= p_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      a_r    <= in_vertex_a;
      b_r    <= in_vertex_b;
      w_r    <= in_edge_weight & WEIGHT_MASK;
    end
    k_r          <= k_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    ik_r         <= ik_nxt;
    p_i_r        <= p_i_nxt;
    p_j_r        <= p_j_nxt;
    p_k_r        <= p_k_nxt;
    out_dist_r   <= out_dist_nxt;
    out_reach_r  <= out_reach_nxt;
    out_via_r    <= out_via_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_distance   = out_dist_r;
  assign out_reachable  = out_reach_r;
  assign out_via_vertex = out_via_r;
  assign out_status     = out_status_r;

  // Checks
  `APSP_ASSERT_IMPLIES(a_result_when_idle, clk, rst_n, out_valid_r, state_r == S_IDLE)
  `APSP_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, start && !busy, state_r == S_EXEC)
  `APSP_ASSERT_IMPLIES(a_stage_in_run, clk, rst_n, p_v_r, relax_phase)
  `APSP_ASSERT_IMPLIES(a_no_diag_update, clk, rst_n, improve, p_i_r != p_j_r)

endmodule

// ===== sim/all_pairs_shortest_path_core_test.sv =====
module all_pairs_shortest_path_core_test;
  import apsp_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int NV           = MAX_VERTICES_DEF;

  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_BAD_VERTEX = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
    logic [EDGE_W-1:0] weight;
  } command_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic [VERT_W-1:0] via;
    logic              status;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic [VERT_W-1:0] in_vertex_a = '0;
  logic [VERT_W-1:0] in_vertex_b = '0;
  logic [EDGE_W-1:0] in_edge_weight = '0;
  logic              out_valid;
  logic [DIST_W-1:0] out_distance;
  logic              out_reachable;
  logic [VERT_W-1:0] out_via_vertex;
  logic              out_status;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [VERT_W-1:0] cfg_data = '0;

  all_pairs_shortest_path_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_vertex_a    (in_vertex_a),
    .in_vertex_b    (in_vertex_b),
    .in_edge_weight (in_edge_weight),
    .out_valid      (out_valid),
    .out_distance   (out_distance),
    .out_reachable  (out_reachable),
    .out_via_vertex (out_via_vertex),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Mirror of the graph state
  bit [DIST_W-1:0] path_len    [0:NV][0:NV];
  bit              path_finite [0:NV][0:NV];
  bit [VERT_W-1:0] path_via    [0:NV][0:NV];
  bit [VERT_W-1:0] model_vcount;

  command_t command_queue[$];
  answer_t  expected_answers[$];
  command_t next_cmd;

  int  queued_total;
  int  accepted_total;
  int  answers_seen;
  int  error_count;
  int  edges_sent;
  int  reads_sent;
  int  runs_sent;
  int  clears_sent;
  int  cfg_writes;
  int  gap_left;
  bit  no_idle;
  bit  item_taken;

  function automatic void clear_paths();
    for (int r = 0; r <= NV; r++) begin
      for (int c = 0; c <= NV; c++) begin
        path_len[r][c]    = '0;
        path_finite[r][c] = (r == c);
        path_via[r][c]    = '0;
      end
    end
  endfunction

  function automatic bit in_range(logic [VERT_W-1:0] v, int n);
    return (v >= 1) && (v <= n);
  endfunction

  // Floyd-Warshall over k, i, j; both directions updated at once
  function automatic void relax_paths(int n);
    bit [DIST_W:0] sum;
    for (int k = 1; k <= n; k++) begin
      for (int i = 1; i <= n; i++) begin
        if (!path_finite[i][k]) continue;
        for (int j = 1; j <= n; j++) begin
          if (!path_finite[k][j]) continue;
          sum = (DIST_W + 1)'(path_len[i][k]) + (DIST_W + 1)'(path_len[k][j]);
          if (sum > DIST_MAX) sum = DIST_MAX;
          if (!path_finite[i][j] || path_len[i][j] > sum) begin
            path_len[i][j]    = sum[DIST_W-1:0];
            path_len[j][i]    = sum[DIST_W-1:0];
            path_finite[i][j] = 1'b1;
            path_finite[j][i] = 1'b1;
            path_via[i][j]    = VERT_W'(k);
            path_via[j][i]    = VERT_W'(k);
          end
        end
      end
    end
  endfunction

  function automatic answer_t predict_answer(command_t cmd);
    answer_t ans;
    int      n;
    ans = '0;
    n = (model_vcount > NV) ? NV : model_vcount;
    case (cmd.func)
      FUNC_CLEAR: clear_paths();
      FUNC_EDGE: begin
        if (!in_range(cmd.vertex_a, n) || !in_range(cmd.vertex_b, n)) begin
          ans.status = STATUS_BAD_VERTEX;
        end else if (cmd.vertex_a != cmd.vertex_b) begin
          path_len[cmd.vertex_a][cmd.vertex_b]    = DIST_W'(cmd.weight & WEIGHT_MASK);
          path_len[cmd.vertex_b][cmd.vertex_a]    = DIST_W'(cmd.weight & WEIGHT_MASK);
          path_finite[cmd.vertex_a][cmd.vertex_b] = 1'b1;
          path_finite[cmd.vertex_b][cmd.vertex_a] = 1'b1;
        end
      end
      FUNC_RUN: relax_paths(n);
      FUNC_READ: begin
        if (!in_range(cmd.vertex_a, n) || !in_range(cmd.vertex_b, n)) begin
          ans.status = STATUS_BAD_VERTEX;
        end else begin
          ans.via = path_via[cmd.vertex_a][cmd.vertex_b];
          if (path_finite[cmd.vertex_a][cmd.vertex_b]) begin
            ans.distance  = path_len[cmd.vertex_a][cmd.vertex_b];
            ans.reachable = 1'b1;
          end
        end
      end
    endcase
    return ans;
  endfunction

  // Monitor: config writes, result checks, then item accepts
  always @(posedge clk) begin
    answer_t want;
    item_taken = 1'b0;
    if (!rst_n) begin
      clear_paths();
      model_vcount = VERT_W'(VCOUNT_RESET);
    end else begin
      if (cfg_valid && cfg_ready === 1'b1) model_vcount = cfg_data;
      if (out_valid === 1'b1) begin
        answers_seen++;
        if (expected_answers.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected answer at %0t: distance %0d reachable %0b via %0d status %0b",
                     $time, out_distance, out_reachable, out_via_vertex, out_status);
        end else begin
          want = expected_answers.pop_front();
          if (out_distance !== want.distance || out_reachable !== want.reachable ||
              out_via_vertex !== want.via || out_status !== want.status) begin
            error_count++;
            if (error_count <= 10)
              $display({"answer %0d mismatch at %0t (expected/actual): distance %0d/%0d ",
                        "reachable %0b/%0b via %0d/%0d status %0b/%0b"},
                       answers_seen, $time, want.distance, out_distance,
                       want.reachable, out_reachable, want.via, out_via_vertex,
                       want.status, out_status);
          end
        end
      end
      if (start && busy === 1'b0) begin
        item_taken = 1'b1;
        accepted_total++;
        want = predict_answer({in_func, in_vertex_a, in_vertex_b, in_edge_weight});
        expected_answers = {expected_answers, want};
      end
    end
  end

  // Driver: one item at a time, with a random gap after each unless no_idle is set
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (command_queue.size() > 0) begin
        next_cmd = command_queue.pop_front();
        in_func        <= next_cmd.func;
        in_vertex_a    <= next_cmd.vertex_a;
        in_vertex_b    <= next_cmd.vertex_b;
        in_edge_weight <= next_cmd.weight;
        start          <= 1'b1;
        gap_left = no_idle ? 0 : $urandom_range(0, 5);
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_command(input logic [FUNC_W-1:0] func, input logic [VERT_W-1:0] a,
                              input logic [VERT_W-1:0] b, input logic [EDGE_W-1:0] w);
    command_t cmd;
    cmd = {func, a, b, w};
    command_queue = {command_queue, cmd};
    queued_total++;
    case (func)
      FUNC_CLEAR: clears_sent++;
      FUNC_EDGE:  edges_sent++;
      FUNC_RUN:   runs_sent++;
      FUNC_READ:  reads_sent++;
    endcase
  endtask

  task automatic wait_for_idle();
    while (accepted_total != queued_total || expected_answers.size() != 0 ||
           busy !== 1'b0)
      @(negedge clk);
  endtask

  task automatic set_vertex_count(input logic [VERT_W-1:0] setting);
    wait_for_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= setting;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [VERT_W-1:0] draw_vertex(int n, bit want_good);
    if (want_good && n > 0) return VERT_W'($urandom_range(1, n));
    if ($urandom_range(0, 3) == 0) return '0;
    return VERT_W'($urandom_range(n + 1, 127));
  endfunction

  function automatic logic [EDGE_W-1:0] draw_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return EDGE_W'($urandom_range(1, 15));
      default: return EDGE_W'($urandom);
    endcase
  endfunction

  // Mostly build-relax-query sequences, with some noise mixed in
  task automatic random_phase(input logic [VERT_W-1:0] setting, input int length);
    int              n;
    int              pick;
    logic [VERT_W-1:0] a;
    set_vertex_count(setting);
    n = (setting > NV) ? NV : setting;
    no_idle = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 3) != 0)
      push_command(FUNC_CLEAR, VERT_W'($urandom), VERT_W'($urandom), EDGE_W'($urandom));
    for (int made = 0; made < length; made++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        push_command(FUNC_EDGE, draw_vertex(n, 1), draw_vertex(n, 1), draw_weight());
      end else if (pick < 45) begin
        if ($urandom_range(0, 1))
          push_command(FUNC_EDGE, draw_vertex(n, 0), draw_vertex(n, 1), draw_weight());
        else
          push_command(FUNC_EDGE, draw_vertex(n, 1), draw_vertex(n, 0), draw_weight());
      end else if (pick < 49) begin
        a = draw_vertex(n, 1);
        push_command(FUNC_EDGE, a, a, draw_weight());
      end else if (pick < 55 && n <= 16) begin
        push_command(FUNC_RUN, VERT_W'($urandom), VERT_W'($urandom), EDGE_W'($urandom));
      end else if (pick < 96) begin
        push_command(FUNC_READ, draw_vertex(n, 1), draw_vertex(n, 1), EDGE_W'($urandom));
      end else begin
        push_command(FUNC_READ, draw_vertex(n, 0), draw_vertex(n, 1), EDGE_W'($urandom));
      end
    end
    if (n <= 16)
      push_command(FUNC_RUN, VERT_W'($urandom), VERT_W'($urandom), EDGE_W'($urandom));
    repeat (8)
      push_command(FUNC_READ, draw_vertex(n, 1), draw_vertex(n, 1), EDGE_W'($urandom));
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset state, range checks, overwrite, self loop and clear at full size
    push_command(FUNC_READ, 7'd1, 7'd1, '0);
    push_command(FUNC_READ, 7'd1, 7'd64, '0);
    push_command(FUNC_READ, 7'd0, 7'd5, '0);
    push_command(FUNC_READ, 7'd3, 7'd65, '0);
    push_command(FUNC_READ, 7'd127, 7'd127, '1);
    push_command(FUNC_EDGE, 7'd1, 7'd64, 16'hFFFF);
    push_command(FUNC_EDGE, 7'd64, 7'd1, 16'h0000);
    push_command(FUNC_READ, 7'd1, 7'd64, '0);
    push_command(FUNC_EDGE, 7'd2, 7'd2, 16'd1234);
    push_command(FUNC_READ, 7'd2, 7'd2, '0);
    push_command(FUNC_EDGE, 7'd0, 7'd1, 16'd5);
    push_command(FUNC_EDGE, 7'd3, 7'd65, 16'd5);
    push_command(FUNC_EDGE, 7'd5, 7'd6, 16'hAAAA);
    push_command(FUNC_CLEAR, 7'd127, 7'd127, 16'hFFFF);
    push_command(FUNC_READ, 7'd5, 7'd6, '0);

    // Small graph with heavy edges and a cheap detour
    set_vertex_count(7'd5);
    push_command(FUNC_EDGE, 7'd1, 7'd2, 16'hFFFF);
    push_command(FUNC_EDGE, 7'd2, 7'd3, 16'hFFFF);
    push_command(FUNC_EDGE, 7'd3, 7'd4, 16'd1);
    push_command(FUNC_EDGE, 7'd4, 7'd5, 16'h5555);
    push_command(FUNC_EDGE, 7'd1, 7'd5, 16'd7);
    push_command(FUNC_RUN, 7'd0, 7'd0, '0);
    push_command(FUNC_READ, 7'd1, 7'd3, '0);
    push_command(FUNC_READ, 7'd1, 7'd4, '0);
    push_command(FUNC_READ, 7'd3, 7'd5, '0);
    push_command(FUNC_READ, 7'd2, 7'd5, '0);
    push_command(FUNC_READ, 7'd6, 7'd1, '0);

    // Extreme counts first, then small random graphs
    random_phase(7'd1, 30);
    random_phase(7'd16, 50);
    random_phase(7'd0, 20);
    random_phase(7'd127, 60);
    random_phase(7'd64, 60);
    random_phase(7'd65, 30);
    while (queued_total < 1100)
      random_phase(VERT_W'($urandom_range(2, 12)), $urandom_range(40, 70));

    // One full-size relaxation over a max-weight chain, count above capacity
    set_vertex_count(7'd100);
    no_idle = 1'b0;
    push_command(FUNC_CLEAR, '0, '0, '0);
    for (int v = 1; v < NV; v++)
      push_command(FUNC_EDGE, VERT_W'(v), VERT_W'(v + 1), 16'hFFFF);
    push_command(FUNC_RUN, '0, '0, '0);
    push_command(FUNC_READ, 7'd1, 7'd64, '0);
    push_command(FUNC_READ, 7'd64, 7'd1, '0);
    push_command(FUNC_READ, 7'd32, 7'd33, '0);
    push_command(FUNC_READ, 7'd65, 7'd1, '0);
    repeat (16)
      push_command(FUNC_READ, draw_vertex(NV, 1), draw_vertex(NV, 1), EDGE_W'($urandom));

    wait_for_idle();
    repeat (16) @(posedge clk);

    $display("covered %0d items: %0d edge loads, %0d pair reads, %0d relaxation runs, %0d clears",
             accepted_total, edges_sent, reads_sent, runs_sent, clears_sent);
    $display("vertex count rewritten %0d times (0, 1, 64, above 64, small graphs); %0d errors",
             cfg_writes, error_count);
    if (expected_answers.size() != 0)
      $display("%0d answers still outstanding", expected_answers.size());
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("all_pairs_shortest_path_core regression: pass");
    end else begin
      $display("all_pairs_shortest_path_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d answers outstanding", expected_answers.size());
    $display("all_pairs_shortest_path_core regression: fail");
    $finish;
  end

endmodule

// ===== all_pairs_shortest_path_core.f =====
+incdir+hw/rtl
hw/rtl/apsp_pkg.sv
hw/rtl/all_pairs_shortest_path_core.sv
sim/all_pairs_shortest_path_core_test.sv
